FILE: hw/rtl/led_bcc_pkg.sv
// ----------------------------------------------------------------------------
// LED blink-code controller package
// Shared types, register indexes, reset values and mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package led_bcc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DurW  = 16;
  localparam int unsigned ModeW = 3;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned SlotW = 3;

  // reset values of the duration registers, in milliseconds
  localparam logic [DurW-1:0] ActHoldRst  = 16'd50;
  localparam logic [DurW-1:0] StatOnRst   = 16'd100;
  localparam logic [DurW-1:0] StatOffRst  = 16'd900;
  localparam logic [DurW-1:0] ErrOnRst    = 16'd200;
  localparam logic [DurW-1:0] ErrOffRst   = 16'd200;

  // slot counter runs first..last and wraps
  localparam logic [SlotW-1:0] SlotFirst = 3'd1;
  localparam logic [SlotW-1:0] SlotLast  = 3'd4;

  typedef enum logic [IdxW-1:0] {
    CFG_ACT_HOLD = 3'd0,
    CFG_STAT_ON  = 3'd1,
    CFG_STAT_OFF = 3'd2,
    CFG_ERR_ON   = 3'd3,
    CFG_ERR_OFF  = 3'd4
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_SHUTDOWN    = 3'd0,
    MODE_OPERATIONAL = 3'd1,
    MODE_ERR0        = 3'd2,
    MODE_ERR1        = 3'd3,
    MODE_ERR2        = 3'd4,
    MODE_ERR3        = 3'd5
  } mode_e;

  typedef struct packed {
    logic [DurW-1:0] act_hold;
    logic [DurW-1:0] stat_on;
    logic [DurW-1:0] stat_off;
    logic [DurW-1:0] err_on;
    logic [DurW-1:0] err_off;
  } cfg_t;

  typedef struct packed {
    logic act;
    logic stat;
    logic err;
  } led_t;

endpackage

`default_nettype wire

FILE: hw/rtl/led_bcc_cfg.sv
// ----------------------------------------------------------------------------
// LED blink-code controller configuration registers
// Write-only duration registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module led_bcc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [led_bcc_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire logic [led_bcc_pkg::DurW-1:0]  cfg_wdata_i,
  output led_bcc_pkg::cfg_t                  cfg_o
);

  led_bcc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        led_bcc_pkg::CFG_ACT_HOLD: cfg_d.act_hold = cfg_wdata_i;
        led_bcc_pkg::CFG_STAT_ON:  cfg_d.stat_on  = cfg_wdata_i;
        led_bcc_pkg::CFG_STAT_OFF: cfg_d.stat_off = cfg_wdata_i;
        led_bcc_pkg::CFG_ERR_ON:   cfg_d.err_on   = cfg_wdata_i;
        led_bcc_pkg::CFG_ERR_OFF:  cfg_d.err_off  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.act_hold <= led_bcc_pkg::ActHoldRst;
      cfg_q.stat_on  <= led_bcc_pkg::StatOnRst;
      cfg_q.stat_off <= led_bcc_pkg::StatOffRst;
      cfg_q.err_on   <= led_bcc_pkg::ErrOnRst;
      cfg_q.err_off  <= led_bcc_pkg::ErrOffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/led_bcc_core.sv
// ----------------------------------------------------------------------------
// LED blink-code controller core
// Timer stamps, slot counter and LED levels, updated once per word.
// ----------------------------------------------------------------------------
`default_nettype none

module led_bcc_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic                          op_i,
  input  wire logic [led_bcc_pkg::TimeW-1:0] now_time_i,
  input  wire logic [led_bcc_pkg::ModeW-1:0] mode_i,
  input  wire led_bcc_pkg::cfg_t             cfg_i,
  output led_bcc_pkg::led_t                  leds_o
);

  logic [led_bcc_pkg::TimeW-1:0] act_on_q, act_on_d, act_off_q, act_off_d;
  logic [led_bcc_pkg::TimeW-1:0] stat_on_q, stat_on_d, stat_off_q, stat_off_d;
  logic [led_bcc_pkg::TimeW-1:0] err_on_q, err_on_d, err_off_q, err_off_d;
  logic [led_bcc_pkg::SlotW-1:0] slot_q, slot_d, slot_inc;
  led_bcc_pkg::led_t             led_q, led_d;

  logic [led_bcc_pkg::TimeW-1:0] act_on_dt, act_off_dt, stat_on_dt, stat_off_dt;
  logic [led_bcc_pkg::TimeW-1:0] err_on_dt, err_off_dt;
  logic is_shut, is_oper, is_err, blanked;

  assign act_on_dt   = now_time_i - act_on_q;
  assign act_off_dt  = now_time_i - act_off_q;
  assign stat_on_dt  = now_time_i - stat_on_q;
  assign stat_off_dt = now_time_i - stat_off_q;
  assign err_on_dt   = now_time_i - err_on_q;
  assign err_off_dt  = now_time_i - err_off_q;

  assign is_shut = (mode_i == led_bcc_pkg::MODE_SHUTDOWN);
  assign is_oper = (mode_i == led_bcc_pkg::MODE_OPERATIONAL);
  assign is_err  = (mode_i >= led_bcc_pkg::MODE_ERR0) && (mode_i <= led_bcc_pkg::MODE_ERR3);

  // advance slot, wrap past the last slot
  always_comb begin
    slot_inc = slot_q + 3'd1;
    if (slot_inc > led_bcc_pkg::SlotLast) slot_inc = led_bcc_pkg::SlotFirst;
  end

  // error code n shows slots 1..n+1; mode code is n+2
  assign blanked = is_err && (slot_inc > (mode_i - 3'd1));

  always_comb begin
    act_on_d   = act_on_q;
    act_off_d  = act_off_q;
    stat_on_d  = stat_on_q;
    stat_off_d = stat_off_q;
    err_on_d   = err_on_q;
    err_off_d  = err_off_q;
    slot_d     = slot_q;
    led_d      = led_q;
    if (op_i) begin
      if ((act_on_q == '0) && (act_off_dt > {16'd0, cfg_i.act_hold})) begin
        led_d.act = 1'b1;
        act_on_d  = now_time_i;
      end
    end else begin
      if ((act_on_q != '0) && (act_on_dt > {16'd0, cfg_i.act_hold})) begin
        led_d.act = 1'b0;
        act_on_d  = '0;
        act_off_d = now_time_i;
      end
      // both tests read the registered on stamp, so the turn-on only follows an idle LED
      if ((stat_on_q != '0) && (stat_on_dt > {16'd0, cfg_i.stat_on})) begin
        led_d.stat = 1'b0;
        stat_on_d  = '0;
        stat_off_d = now_time_i;
      end
      if ((stat_on_q == '0) && (stat_off_dt > {16'd0, cfg_i.stat_off})) begin
        led_d.stat = 1'b1;
        stat_on_d  = now_time_i;
      end
      if (is_shut) begin
        led_d.err = 1'b1;
        err_on_d  = now_time_i;
        slot_d    = '0;
      end else if (is_oper) begin
        led_d.err = 1'b0;
        err_on_d  = '0;
        err_off_d = now_time_i;
        slot_d    = '0;
      end else begin
        if ((err_on_q != '0) && (err_on_dt > {16'd0, cfg_i.err_on})) begin
          led_d.err = 1'b0;
          err_on_d  = '0;
          err_off_d = now_time_i;
        end
        if ((err_on_q == '0) && (err_off_dt > {16'd0, cfg_i.err_off})) begin
          slot_d   = slot_inc;
          err_on_d = now_time_i;
          if (!blanked) led_d.err = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_on_q   <= '0;
      act_off_q  <= '0;
      stat_on_q  <= '0;
      stat_off_q <= '0;
      err_on_q   <= '0;
      err_off_q  <= '0;
      slot_q     <= '0;
      led_q      <= '0;
    end else if (step_i) begin
      act_on_q   <= act_on_d;
      act_off_q  <= act_off_d;
      stat_on_q  <= stat_on_d;
      stat_off_q <= stat_off_d;
      err_on_q   <= err_on_d;
      err_off_q  <= err_off_d;
      slot_q     <= slot_d;
      led_q      <= led_d;
    end
  end

  assign leds_o = led_d;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= led_bcc_pkg::SlotLast)
    else $error("slot counter out of range");

  a_oper_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !op_i && is_oper) |=> (!led_q.err && slot_q == '0 && err_on_q == '0))
    else $error("operational tick left error LED lit");

  a_shut_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !op_i && is_shut) |=> (led_q.err && slot_q == '0))
    else $error("shutdown tick left error LED dark");

  a_event_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && op_i) |=> ($stable(led_q.stat) && $stable(led_q.err) && $stable(slot_q)))
    else $error("bus event touched status or error state");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(led_q) && $stable(act_on_q) && $stable(err_on_q)))
    else $error("state changed without a word");

endmodule

`default_nettype wire

FILE: hw/rtl/led_blink_code_controller_unit.sv
// ----------------------------------------------------------------------------
// LED blink-code controller
// Activity, heartbeat and blink-code LEDs driven from millisecond timestamps.
// ----------------------------------------------------------------------------
// Each accepted word (a tick or a bus event with its timestamp and mode) yields
// one result word holding the three LED levels after it. The block takes one
// word per clock while the output is not stalled; a result is offered once the
// input register has fed the update of the timer stamps into the result
// register. Stalls on the output hold the result register and back up through
// the input register. The user must write the duration registers through the
// cfg port only while no word is in flight; the block does not enforce this.
`default_nettype none

module led_blink_code_controller_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [led_bcc_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire logic [led_bcc_pkg::DurW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [led_bcc_pkg::TimeW-1:0] now_time_i,
  input  wire logic [led_bcc_pkg::ModeW-1:0] mode_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               activity_led_o,
  output logic                               status_led_o,
  output logic                               error_led_o
);

  led_bcc_pkg::cfg_t cfg;
  led_bcc_pkg::led_t leds_next;

  logic                          in_vld_q, in_vld_d;
  logic                          op_q;
  logic [led_bcc_pkg::TimeW-1:0] now_q;
  logic [led_bcc_pkg::ModeW-1:0] mode_q;
  logic                          out_vld_q, out_vld_d;
  led_bcc_pkg::led_t             leds_q;
  logic                          in_acc, advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc)       in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (advance)          out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_i;
      now_q  <= now_time_i;
      mode_q <= mode_i;
    end
    if (advance) leds_q <= leds_next;
  end

  led_bcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  led_bcc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .op_i       (op_q),
    .now_time_i (now_q),
    .mode_i     (mode_q),
    .cfg_i      (cfg),
    .leds_o     (leds_next)
  );

  assign out_valid_o    = out_vld_q;
  assign activity_led_o = leds_q.act;
  assign status_led_o   = leds_q.stat;
  assign error_led_o    = leds_q.err;

endmodule

`default_nettype wire
